>>> hdl/bfsh_pkg.sv
package bfsh_pkg;

  // Default sizing, handed to the top level as parameter defaults.
  localparam int FILTER_BITS_DEF = 65536;
  localparam int HASH_COUNT_DEF  = 7;

  // Hash slot counter width: three bits, slot indices 0 to 7.
  localparam int K_W = 3;

  // Operation codes carried in tuser.
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  // Hash seeds and multipliers.
  localparam logic [31:0] RS_MULT_SEED = 32'd63689;
  localparam logic [31:0] RS_MULT_STEP = 32'd378551;
  localparam logic [31:0] DJB_SEED     = 32'd5381;
  localparam logic [31:0] JS_SEED      = 32'd1315423911;
  localparam logic [31:0] FNV_MULT     = 32'h811C9DC5;
  localparam logic [31:0] PJW_KEEP     = 32'h0FFFFFFF;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL_RS,
    ST_MUL_RM,
    ST_MUL_FNV,
    ST_MOD_Q,
    ST_MOD_R,
    ST_MOD_FIX,
    ST_PROBE,
    ST_CHECK,
    ST_OUT
  } state_t;

endpackage

>>> hdl/bloom_filter_seven_hash.sv
// Each key byte is accepted, then takes the RS, RS multiplier and FNV passes through the
// shared 32x32 multiplier; after the last byte, each of the HASH_COUNT hashes takes two
// multiplier passes and a correction for hash % FILTER_BITS, a store read and a check,
// then the result waits for the output register. A new byte is taken only once idle.
// Reset: rst is synchronous, active high; a clearing pass then writes FILTER_BITS
// store bits, one per cycle, during which s_tready stays low.
module bloom_filter_seven_hash #(
  parameter int FILTER_BITS = bfsh_pkg::FILTER_BITS_DEF,
  parameter int HASH_COUNT  = bfsh_pkg::HASH_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Key byte stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] key_byte, [19:8] key_length, [23:20] zero
  input  logic        s_tlast,   // last_byte
  input  logic [1:0]  s_tuser,   // func
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] key_present, [7:1] zero
  output logic [1:0]  m_tuser    // done_func
);

  localparam int IDX_W = $clog2(FILTER_BITS);
  localparam logic [31:0]        MOD_N     = 32'(FILTER_BITS);
  localparam logic [31:0]        RECIP     = 32'(64'h1_0000_0000 / 64'(FILTER_BITS));
  localparam logic [IDX_W-1:0]   LAST_ADDR = IDX_W'(FILTER_BITS - 1);
  localparam logic [bfsh_pkg::K_W-1:0] LAST_K = bfsh_pkg::K_W'(HASH_COUNT - 1);

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  bfsh_pkg::state_t state, state_next;
  logic             at_key_start, at_key_start_next;
  logic             m_tvalid_next;
  logic [bfsh_pkg::K_W-1:0] k_idx, k_idx_next;
  logic [IDX_W-1:0] clr_addr, clr_addr_next;

  logic             s_accept;
  logic             out_load;

  // ---------------------------------------------------------------------------
  // Datapath registers (no reset: every one is loaded before use)
  // ---------------------------------------------------------------------------
  logic [31:0] rs_acc, rs_mult, djb_acc, fnv_acc, js_acc, pjw_acc, sdbm_acc, dek_acc;
  logic [7:0]  c_q;
  logic        last_q;
  logic [1:0]  func_q;
  logic [31:0] div_word;
  logic [31:0] quot;
  logic [IDX_W-1:0] rem;
  logic        all_set;
  logic        rd_q;
  logic        key_present_q;
  logic [1:0]  done_func_q;

  // Filter bit store, one bit per entry.
  logic        store [FILTER_BITS];
  logic [IDX_W-1:0] mem_addr;
  logic        mem_we;
  logic        mem_wd;

  // Input word fields
  logic [7:0]  in_byte;
  logic [11:0] in_len;
  assign in_byte = s_tdata[7:0];
  assign in_len  = s_tdata[19:8];

  assign s_accept = s_tvalid && s_tready;
  assign s_tready = (state == bfsh_pkg::ST_IDLE);

  // ---------------------------------------------------------------------------
  // Seeded values: a first byte starts from the seeds, later bytes from the
  // running accumulators.
  // ---------------------------------------------------------------------------
  logic [31:0] rs_s, rm_s, djb_s, fnv_s, js_s, pjw_s, sdbm_s, dek_s;
  logic [31:0] c32;
  logic [31:0] djb_new, js_new, pjw_sum, pjw_new, sdbm_new, dek_new;

  always_comb begin
    rs_s   = at_key_start ? 32'd0                  : rs_acc;
    rm_s   = at_key_start ? bfsh_pkg::RS_MULT_SEED : rs_mult;
    djb_s  = at_key_start ? bfsh_pkg::DJB_SEED     : djb_acc;
    fnv_s  = at_key_start ? 32'd0                  : fnv_acc;
    js_s   = at_key_start ? bfsh_pkg::JS_SEED      : js_acc;
    pjw_s  = at_key_start ? 32'd0                  : pjw_acc;
    sdbm_s = at_key_start ? 32'd0                  : sdbm_acc;
    dek_s  = at_key_start ? {20'd0, in_len}        : dek_acc;
    c32    = {24'd0, in_byte};

    // Shift-and-add hashes update in the accept cycle.
    djb_new  = (djb_s << 5) + djb_s + c32;
    js_new   = js_s ^ ((js_s << 5) + c32 + (js_s >> 2));
    pjw_sum  = (pjw_s << 4) + c32;
    if (pjw_sum[31:28] != 4'd0) begin
      pjw_new = (pjw_sum ^ {24'd0, pjw_sum[31:28], 4'd0}) & bfsh_pkg::PJW_KEEP;
    end else begin
      pjw_new = pjw_sum;
    end
    sdbm_new = c32 + (sdbm_s << 6) + (sdbm_s << 16) - sdbm_s;
    dek_new  = ((dek_s << 5) ^ (dek_s >> 27)) ^ c32;
  end

  // Pick the hash for the current probe slot.
  logic [31:0] hash_sel;
  always_comb begin
    case (k_idx)
      3'd0:    hash_sel = rs_acc;
      3'd1:    hash_sel = djb_acc;
      3'd2:    hash_sel = fnv_acc;
      3'd3:    hash_sel = js_acc;
      3'd4:    hash_sel = pjw_acc;
      3'd5:    hash_sel = sdbm_acc;
      default: hash_sel = dek_acc;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier: RS step, RS multiplier step and FNV step take turns,
  // then the two passes of hash % FILTER_BITS.
  // ---------------------------------------------------------------------------
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_full;
  logic [31:0] prod;

  always_comb begin
    mul_a = rs_acc;
    mul_b = rs_mult;
    unique case (state)
      bfsh_pkg::ST_MUL_RM: begin
        mul_a = rs_mult;
        mul_b = bfsh_pkg::RS_MULT_STEP;
      end
      bfsh_pkg::ST_MUL_FNV: begin
        mul_a = fnv_acc;
        mul_b = bfsh_pkg::FNV_MULT;
      end
      bfsh_pkg::ST_MOD_Q: begin
        mul_a = hash_sel;
        mul_b = RECIP;
      end
      bfsh_pkg::ST_MOD_R: begin
        mul_a = quot;
        mul_b = MOD_N;
      end
      default: begin
        mul_a = rs_acc;
        mul_b = rs_mult;
      end
    endcase
    mul_full = {32'd0, mul_a} * {32'd0, mul_b};
    prod     = mul_full[31:0];
  end

  // The quotient from the reciprocal is exact or one short, so the
  // difference hash - quot*FILTER_BITS needs at most one more subtract.
  logic [31:0] rem_fix;
  assign rem_fix = (div_word >= MOD_N) ? (div_word - MOD_N) : div_word;

  // ---------------------------------------------------------------------------
  // Sequencer: next state and control outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next        = state;
    at_key_start_next = at_key_start;
    k_idx_next        = k_idx;
    clr_addr_next     = clr_addr;
    out_load          = 1'b0;
    m_tvalid_next     = m_tvalid && !m_tready;
    mem_addr          = rem;
    mem_we            = 1'b0;
    mem_wd            = 1'b0;

    unique case (state)
      bfsh_pkg::ST_CLEAR: begin
        // Sweep the store to zero after reset.
        mem_addr      = clr_addr;
        mem_we        = 1'b1;
        mem_wd        = 1'b0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == LAST_ADDR) begin
          state_next = bfsh_pkg::ST_IDLE;
        end
      end
      bfsh_pkg::ST_IDLE: begin
        if (s_accept) begin
          state_next = bfsh_pkg::ST_MUL_RS;
        end
      end
      bfsh_pkg::ST_MUL_RS: begin
        state_next = bfsh_pkg::ST_MUL_RM;
      end
      bfsh_pkg::ST_MUL_RM: begin
        state_next = bfsh_pkg::ST_MUL_FNV;
      end
      bfsh_pkg::ST_MUL_FNV: begin
        at_key_start_next = last_q;
        k_idx_next        = '0;
        if (!last_q || func_q == bfsh_pkg::FUNC_NONE) begin
          // Mid-key byte, or a key that ends with no operation: no result.
          state_next = bfsh_pkg::ST_IDLE;
        end else begin
          state_next = bfsh_pkg::ST_MOD_Q;
        end
      end
      bfsh_pkg::ST_MOD_Q: begin
        state_next = bfsh_pkg::ST_MOD_R;
      end
      bfsh_pkg::ST_MOD_R: begin
        state_next = bfsh_pkg::ST_MOD_FIX;
      end
      bfsh_pkg::ST_MOD_FIX: begin
        state_next = bfsh_pkg::ST_PROBE;
      end
      bfsh_pkg::ST_PROBE: begin
        // Insert sets and clear resets the bit; lookup only reads it.
        mem_addr = rem;
        mem_we   = (func_q == bfsh_pkg::FUNC_INSERT) || (func_q == bfsh_pkg::FUNC_CLEAR);
        mem_wd   = (func_q == bfsh_pkg::FUNC_INSERT);
        state_next = bfsh_pkg::ST_CHECK;
      end
      bfsh_pkg::ST_CHECK: begin
        k_idx_next = k_idx + 1'b1;
        if (k_idx == LAST_K) begin
          state_next = bfsh_pkg::ST_OUT;
        end else begin
          state_next = bfsh_pkg::ST_MOD_Q;
        end
      end
      bfsh_pkg::ST_OUT: begin
        // Hold until the output register is free.
        if (!m_tvalid || m_tready) begin
          out_load      = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = bfsh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bfsh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bfsh_pkg::ST_CLEAR;
      at_key_start <= 1'b1;
      m_tvalid     <= 1'b0;
      k_idx        <= '0;
      clr_addr     <= '0;
    end else begin
      state        <= state_next;
      at_key_start <= at_key_start_next;
      m_tvalid     <= m_tvalid_next;
      k_idx        <= k_idx_next;
      clr_addr     <= clr_addr_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      bfsh_pkg::ST_IDLE: begin
        if (s_accept) begin
          c_q      <= in_byte;
          last_q   <= s_tlast;
          func_q   <= s_tuser;
          rs_acc   <= rs_s;
          rs_mult  <= rm_s;
          fnv_acc  <= fnv_s;
          djb_acc  <= djb_new;
          js_acc   <= js_new;
          pjw_acc  <= pjw_new;
          sdbm_acc <= sdbm_new;
          dek_acc  <= dek_new;
        end
      end
      bfsh_pkg::ST_MUL_RS: begin
        rs_acc <= prod + {24'd0, c_q};
      end
      bfsh_pkg::ST_MUL_RM: begin
        rs_mult <= prod;
      end
      bfsh_pkg::ST_MUL_FNV: begin
        fnv_acc <= prod ^ {24'd0, c_q};
        all_set <= 1'b1;
      end
      bfsh_pkg::ST_MOD_Q: begin
        div_word <= hash_sel;
        quot     <= mul_full[63:32];
      end
      bfsh_pkg::ST_MOD_R: begin
        div_word <= div_word - prod;
      end
      bfsh_pkg::ST_MOD_FIX: begin
        rem <= rem_fix[IDX_W-1:0];
      end
      bfsh_pkg::ST_CHECK: begin
        all_set <= all_set & rd_q;
      end
      bfsh_pkg::ST_OUT: begin
        if (out_load) begin
          key_present_q <= (func_q == bfsh_pkg::FUNC_LOOKUP) && all_set;
          done_func_q   <= func_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Store: one write port, one registered read port at the same address.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_addr] <= mem_wd;
    end
    rd_q <= store[mem_addr];
  end

  assign m_tdata = {7'd0, key_present_q};
  assign m_tuser = done_func_q;

endmodule
